[hw/rtl/bsbp_pkg.sv]
`timescale 1ns / 1ps

package bsbp_pkg;

  localparam int CFG_W       = 17;
  localparam int POS_W       = 16;
  localparam int CNT_W       = 17;
  localparam int DATA_W      = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] CFG_RESET = 17'd65536;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_FLUSH
  } bsbp_state_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } bsbp_res_t;

endpackage

[hw/rtl/bitmap_set_bit_positions.sv]
// Scan: a word is scanned one bit per cycle unless a new hit stalls on a full output register,
//   ending early at the valid length, then the FLUSH state releases the held position; a result
//   is pushed into the output register, which drives out_tvalid, when the next set bit is found or at the flush.
// A new word is taken only once the scan of the last word is through and idle again; a stalled
//   output beat holds the scan.
// Reset (rst_n low, synchronous): valid length 65536, bit base and running count zero.
`timescale 1ns / 1ps

module bitmap_set_bit_positions #(
  parameter int MAX_BITS  = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [bsbp_pkg::CFG_W-1:0]           cfg_wr_data,  // valid_bit_count
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [bsbp_pkg::DATA_W-1:0]          in_tdata,     // bitmap_word
  input  logic                                 in_tuser,     // restart
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [bsbp_pkg::OUT_TDATA_W-1:0]     out_tdata,    // bit_position, running_count
  output logic                                 out_tlast     // last_of_word
);

  localparam int BW = $clog2(MAX_BITS + 1);
  localparam int LW = (BW > bsbp_pkg::CFG_W) ? BW : bsbp_pkg::CFG_W;
  localparam int PW = LW + 1;

  logic [bsbp_pkg::CFG_W-1:0] cfg_r;
  logic [BW-1:0]              word_base_r, word_base_nxt;
  logic [BW-1:0]              base_start;
  logic [BW:0]                base_sum;
  logic [LW-1:0]              cfg_ext, limit;
  logic                       in_acc, scan_idle, push, free;
  bsbp_pkg::bsbp_res_t        push_res, out_res;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = scan_idle;

  assign cfg_ext = LW'(cfg_r);
  assign limit   = (cfg_ext > LW'(MAX_BITS)) ? LW'(MAX_BITS) : cfg_ext;

  assign base_start = in_tuser ? '0 : word_base_r;
  assign base_sum   = {1'b0, base_start} + (BW + 1)'(WORD_BITS);

  always_comb begin
    word_base_nxt = word_base_r;
    if (in_acc) begin
      word_base_nxt = (base_sum >= (BW + 1)'(MAX_BITS)) ? BW'(MAX_BITS) : base_sum[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= bsbp_pkg::CFG_RESET;
      word_base_r <= '0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      word_base_r <= word_base_nxt;
    end
  end

  bsbp_scan #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW),
    .PW        (PW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (in_acc),
    .word_i    (in_tdata),
    .base_i    (base_start),
    .restart_i (in_tuser),
    .limit_i   (PW'(limit)),
    .free_i    (free),
    .idle_o    (scan_idle),
    .push_o    (push),
    .res_o     (push_res)
  );

  bsbp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .res_i      (push_res),
    .free_o     (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {7'd0, out_res.cnt, out_res.pos};
  assign out_tlast = out_res.last;

`ifndef ASSERT_OFF
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("scanner accepted a beat but stayed idle");

  a_pos_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (MAX_BITS > 65536) || (LW'(out_tdata[15:0]) < limit))
    else $error("emitted position at or above valid length");

  a_base_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    word_base_r <= BW'(MAX_BITS))
    else $error("word base beyond maximum");
`endif

endmodule

[hw/rtl/bsbp_obuf.sv]
`timescale 1ns / 1ps

module bsbp_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_i,
  input  bsbp_pkg::bsbp_res_t res_i,
  output logic                free_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output bsbp_pkg::bsbp_res_t out_res
);

  logic                vld_r, vld_nxt;
  bsbp_pkg::bsbp_res_t res_r, res_nxt;

  assign free_o     = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_res    = res_r;

  always_comb begin
    vld_nxt = vld_r;
    res_nxt = res_r;
    if (push_i) begin
      vld_nxt = 1'b1;
      res_nxt = res_i;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

[hw/rtl/bsbp_scan.sv]
`timescale 1ns / 1ps

module bsbp_scan #(
  parameter int WORD_BITS = 64,
  parameter int BW        = 17,
  parameter int PW        = 18
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             load_i,
  input  logic [bsbp_pkg::DATA_W-1:0]      word_i,
  input  logic [BW-1:0]                    base_i,
  input  logic                             restart_i,
  input  logic [PW-1:0]                    limit_i,
  input  logic                             free_i,
  output logic                             idle_o,
  output logic                             push_o,
  output bsbp_pkg::bsbp_res_t              res_o
);

  localparam int IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [bsbp_pkg::DATA_W-1:0] WMASK =
    (WORD_BITS >= bsbp_pkg::DATA_W) ? {bsbp_pkg::DATA_W{1'b1}} :
    ((64'd1 << WORD_BITS) - 64'd1);

  bsbp_pkg::bsbp_state_t state_r, state_nxt;

  logic [bsbp_pkg::DATA_W-1:0] sh_r, sh_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic [bsbp_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        held_vld_r, held_vld_nxt;
  logic [bsbp_pkg::POS_W-1:0]  held_pos_r, held_pos_nxt;
  logic [bsbp_pkg::CNT_W-1:0]  held_cnt_r, held_cnt_nxt;

  logic in_range, hit, scan_end, stall;

  assign in_range = pos_r < limit_i;
  assign hit      = sh_r[0] && in_range;
  assign scan_end = !in_range || (idx_r == IW'(WORD_BITS - 1));
  // a new hit can only replace the held one if the older one can leave
  assign stall    = hit && held_vld_r && !free_i;
  assign idle_o   = (state_r == bsbp_pkg::SCAN_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsbp_pkg::SCAN_IDLE: begin
        if (load_i) state_nxt = bsbp_pkg::SCAN_RUN;
      end
      bsbp_pkg::SCAN_RUN: begin
        if (!stall && scan_end) state_nxt = bsbp_pkg::SCAN_FLUSH;
      end
      bsbp_pkg::SCAN_FLUSH: begin
        if (!held_vld_r || free_i) state_nxt = bsbp_pkg::SCAN_IDLE;
      end
      default: state_nxt = bsbp_pkg::SCAN_IDLE;
    endcase
  end

  always_comb begin
    sh_nxt       = sh_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    held_vld_nxt = held_vld_r;
    held_pos_nxt = held_pos_r;
    held_cnt_nxt = held_cnt_r;
    push_o       = 1'b0;
    res_o.pos    = held_pos_r;
    res_o.cnt    = held_cnt_r;
    res_o.last   = 1'b0;
    case (state_r)
      bsbp_pkg::SCAN_IDLE: begin
        if (load_i) begin
          sh_nxt  = word_i & WMASK;
          pos_nxt = PW'(base_i);
          idx_nxt = '0;
          if (restart_i) cnt_nxt = '0;
        end
      end
      bsbp_pkg::SCAN_RUN: begin
        if (!stall) begin
          if (hit) begin
            push_o       = held_vld_r;
            held_vld_nxt = 1'b1;
            held_pos_nxt = pos_r[bsbp_pkg::POS_W-1:0];
            held_cnt_nxt = cnt_r + 17'd1;
            cnt_nxt      = cnt_r + 17'd1;
          end
          sh_nxt  = sh_r >> 1;
          pos_nxt = pos_r + PW'(1);
          idx_nxt = idx_r + IW'(1);
        end
      end
      bsbp_pkg::SCAN_FLUSH: begin
        res_o.last = 1'b1;
        if (held_vld_r && free_i) begin
          push_o       = 1'b1;
          held_vld_nxt = 1'b0;
        end
      end
      default: begin
        held_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bsbp_pkg::SCAN_IDLE;
      held_vld_r <= 1'b0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      held_vld_r <= held_vld_nxt;
      cnt_r      <= cnt_nxt;
    end
    sh_r       <= sh_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    held_pos_r <= held_pos_nxt;
    held_cnt_r <= held_cnt_nxt;
  end

endmodule

[dv/bitmap_set_bit_positions_checker.sv]
`timescale 1ns / 1ps

module bitmap_set_bit_positions_checker #(
  parameter int MAX_BITS  = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bsbp_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [bsbp_pkg::DATA_W-1:0]        in_tdata,
  input  logic                               in_tuser,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [bsbp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               out_tlast,
  output int                                 errors,
  output int                                 pending
);

  localparam int PAD_LSB = bsbp_pkg::POS_W + bsbp_pkg::CNT_W;

  bsbp_pkg::bsbp_res_t        positions_q[$];
  logic [bsbp_pkg::CFG_W-1:0] valid_bits = bsbp_pkg::CFG_RESET;
  int unsigned                word_base = 0;
  int unsigned                emitted = 0;
  int                         fail_n = 0;

  function automatic void predict_positions(input logic [bsbp_pkg::DATA_W-1:0] word,
                                            input logic restart);
    int unsigned         limit;
    int unsigned         pos;
    bsbp_pkg::bsbp_res_t held;
    logic                have;
    logic                stop;
    have = 1'b0;
    stop = 1'b0;
    held = '0;
    if (restart) begin
      word_base = 0;
      emitted   = 0;
    end
    limit = (valid_bits > MAX_BITS) ? MAX_BITS : valid_bits;
    if (word_base < limit) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (!stop && word[b]) begin
          pos = word_base + b;
          if (pos >= limit) begin
            stop = 1'b1;
          end else begin
            emitted = (emitted + 1) & 32'h1FFFF;
            if (have) positions_q.push_back(held);
            held.pos  = pos[bsbp_pkg::POS_W-1:0];
            held.cnt  = emitted[bsbp_pkg::CNT_W-1:0];
            held.last = 1'b0;
            have      = 1'b1;
          end
        end
      end
    end
    if (have) begin
      held.last = 1'b1;
      positions_q.push_back(held);
    end
    word_base = (word_base + WORD_BITS >= MAX_BITS) ? MAX_BITS : word_base + WORD_BITS;
  endfunction

  always @(posedge clk) begin
    bsbp_pkg::bsbp_res_t        exp_res;
    logic [bsbp_pkg::POS_W-1:0] got_pos;
    logic [bsbp_pkg::CNT_W-1:0] got_cnt;
    got_pos = out_tdata[bsbp_pkg::POS_W-1:0];
    got_cnt = out_tdata[PAD_LSB-1:bsbp_pkg::POS_W];
    if (!rst_n) begin
      positions_q.delete();
      valid_bits = bsbp_pkg::CFG_RESET;
      word_base  = 0;
      emitted    = 0;
    end else begin
      if (cfg_wr_en) valid_bits = cfg_wr_data;
      if (in_tvalid && in_tready) predict_positions(in_tdata, in_tuser);
      if (out_tvalid && out_tready) begin
        if (positions_q.size() == 0) begin
          $error("unexpected beat: bit_position %0d running_count %0d", got_pos, got_cnt);
          fail_n++;
        end else begin
          exp_res = positions_q.pop_front();
          if (got_pos !== exp_res.pos) begin
            $error("bit_position: expected %0d, got %0d", exp_res.pos, got_pos);
            fail_n++;
          end
          if (got_cnt !== exp_res.cnt) begin
            $error("running_count: expected %0d, got %0d", exp_res.cnt, got_cnt);
            fail_n++;
          end
          if (out_tlast !== exp_res.last) begin
            $error("last_of_word: expected %0d, got %0d", exp_res.last, out_tlast);
            fail_n++;
          end
          if (out_tdata[bsbp_pkg::OUT_TDATA_W-1:PAD_LSB] !== '0) begin
            $error("tdata_pad: expected 0, got %0h",
                   out_tdata[bsbp_pkg::OUT_TDATA_W-1:PAD_LSB]);
            fail_n++;
          end
        end
      end
    end
    errors  <= fail_n;
    pending <= positions_q.size();
  end

endmodule

[dv/bitmap_set_bit_positions_test.sv]
`timescale 1ns / 1ps

module bitmap_set_bit_positions_test;

  localparam int MAX_BITS  = 65536;
  localparam int WORD_BITS = 64;
  localparam int DRAIN_CYC = 2 * WORD_BITS + 16;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_wr_en = 1'b0;
  logic [bsbp_pkg::CFG_W-1:0]       cfg_wr_data = '0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [bsbp_pkg::DATA_W-1:0]      in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bsbp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tlast;
  int                               errors;
  int                               pending;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #6 clk = ~clk;

  bitmap_set_bit_positions #(
    .MAX_BITS (MAX_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  bitmap_set_bit_positions_checker #(
    .MAX_BITS (MAX_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .errors     (errors),
    .pending    (pending)
  );

  // receiver: random backpressure, one long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done  <= 1'b1;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet || ($urandom_range(0, 99) >= 24);
    end
  end

  initial begin
    #30_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(input logic [bsbp_pkg::DATA_W-1:0] word, input logic restart);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= restart;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_limit(input logic [bsbp_pkg::CFG_W-1:0] limit);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [bsbp_pkg::DATA_W-1:0] rand_word();
    logic [bsbp_pkg::DATA_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(0, 63);
      3, 4, 5: w = w & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  // bitmaps of random length; a few stray restarts mid-bitmap
  task automatic run_bitmaps(input int n_words);
    int sent;
    int len;
    sent = 0;
    while (sent < n_words) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        send_word(rand_word(), (i == 0) ? 1'b1 : ($urandom_range(0, 15) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length, first word without restart
    send_word(64'h0000_0000_0000_0001, 1'b0);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(64'h8000_0000_0000_0000, 1'b1);
    send_word(64'h5555_5555_5555_5555, 1'b0);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_word({$urandom, $urandom}, 1'b1);

    write_limit(17'd0);
    send_word('1, 1'b1);
    send_word('1, 1'b0);

    write_limit(17'd1);
    send_word('1, 1'b1);
    send_word(64'h0000_0000_0000_0002, 1'b1);

    write_limit(17'd70);
    send_word('1, 1'b1);
    send_word('1, 1'b0);
    send_word('1, 1'b0);
    send_word(64'h8000_0000_0000_0001, 1'b1);
    send_word(64'h0000_0000_0000_0060, 1'b0);

    write_limit(17'h1FFFF);
    send_word('1, 1'b1);
    send_word(64'hF0F0_0000_0000_0F0F, 1'b0);

    write_limit(17'd100000);
    send_word(64'h0123_4567_89AB_CDEF, 1'b1);

    write_limit(17'd65536);
    quiet <= 1'b1;
    run_bitmaps(30);
    quiet <= 1'b0;

    write_limit(17'($urandom_range(128, 600)));
    hold_req <= 1'b1;
    run_bitmaps(40);

    write_limit(17'h1FFFF);
    run_bitmaps(30);

    write_limit(17'(64 * $urandom_range(1, 8)));
    run_bitmaps(30);

    write_limit(17'($urandom_range(0, 131071)));
    run_bitmaps(30);

    // dense words at the full valid length
    write_limit(17'd65536);
    for (int i = 0; i < 4; i++) send_word('1, i == 0);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/bsbp_pkg.sv
hw/rtl/bsbp_obuf.sv
hw/rtl/bsbp_scan.sv
hw/rtl/bitmap_set_bit_positions.sv
dv/bitmap_set_bit_positions_checker.sv
dv/bitmap_set_bit_positions_test.sv
